// ===== rtl/lks_pkg.sv =====
package lks_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W    = IDX_W;
  localparam int PR_W      = RANK_W + 1;
  localparam int OCC_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int FIELD_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [OCC_W-1:0]     occ_t;

  typedef enum logic {
    REQ_PUT = 1'b0,
    REQ_GET = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_t;

  typedef struct packed {
    logic                      req_type;
    logic signed [FIELD_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                status;
    logic signed [FIELD_W-1:0] result_key;
    logic signed [FIELD_W-1:0] evicted_key;
  } out_item_t;

  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    rank_t hit_rank;
    idx_t  free_idx;
    idx_t  victim_idx;
  } lookup_t;

  function automatic key_t key_from_field(logic [FIELD_W-1:0] f);
    return KEY_WIDTH'(f);
  endfunction

  function automatic logic [FIELD_W-1:0] key_to_field(key_t k);
    return FIELD_W'(k);
  endfunction

endpackage

// ===== rtl/lru_key_set.sv =====
// channel | ports                         | dir | beat
// in      | in_valid, in_stall, in_data   | in  | req_type, key
// out     | out_valid, out_stall, out_data| out | status, result_key, evicted_key
// cfg     | cfg_valid, cfg_ready, cfg_data| in  | cap_in_use
// One request per cycle sustained while out_stall is low; an input beat passes through
// the input register, then lookup and rank update into the result register.
// Reset: set empty, cap_in_use = 16. cfg_ready is always high.
// out_stall backs up into in_stall only while both registers hold beats.
module lru_key_set (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lks_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lks_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lks_pkg::CAP_W-1:0]  cfg_data
);

  logic                      s1_valid_r;
  lks_pkg::in_item_t         s1_data_r;
  logic                      out_valid_r;
  lks_pkg::out_item_t        out_data_r;
  logic [lks_pkg::CAP_W-1:0] cap_r;
  logic                      fire;
  lks_pkg::out_item_t        res;

  assign fire      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !fire;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lks_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_data_r),
    .cap   (cap_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= lks_pkg::CAP_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a held beat");

  a_fire_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed beat not presented");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result lost");

endmodule

// ===== rtl/lks_lookup.sv =====
module lks_lookup (
  input  lks_pkg::key_t   key,
  input  logic            valid   [lks_pkg::ENTRIES],
  input  lks_pkg::key_t   keys    [lks_pkg::ENTRIES],
  input  lks_pkg::rank_t  ranks   [lks_pkg::ENTRIES],
  input  lks_pkg::occ_t   occ,
  output lks_pkg::lookup_t lk
);

  logic [lks_pkg::ENTRIES-1:0] hit_vec;
  logic [lks_pkg::ENTRIES-1:0] victim_vec;
  lks_pkg::rank_t              lru_rank;

  assign lru_rank = lks_pkg::RANK_W'(occ - lks_pkg::OCC_W'(1));

  always_comb begin
    for (int i = 0; i < lks_pkg::ENTRIES; i++) begin
      hit_vec[i]    = valid[i] && (keys[i] == key);
      victim_vec[i] = valid[i] && (ranks[i] == lru_rank);
    end
  end

  always_comb begin
    lk = '0;
    lk.hit = |hit_vec;
    for (int i = 0; i < lks_pkg::ENTRIES; i++) begin
      if (hit_vec[i]) begin
        lk.hit_idx  = lk.hit_idx | lks_pkg::IDX_W'(i);
        lk.hit_rank = lk.hit_rank | ranks[i];
      end
      if (victim_vec[i]) begin
        lk.victim_idx = lk.victim_idx | lks_pkg::IDX_W'(i);
      end
    end
    for (int i = lks_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        lk.free_idx = lks_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/lks_store.sv =====
module lks_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  lks_pkg::in_item_t          item,
  input  logic [lks_pkg::CAP_W-1:0]  cap,
  output lks_pkg::out_item_t         res
);

  lks_pkg::key_t  keys_r   [lks_pkg::ENTRIES];
  lks_pkg::key_t  keys_nxt [lks_pkg::ENTRIES];
  logic           valid_r   [lks_pkg::ENTRIES];
  logic           valid_nxt [lks_pkg::ENTRIES];
  lks_pkg::rank_t ranks_r   [lks_pkg::ENTRIES];
  lks_pkg::rank_t ranks_nxt [lks_pkg::ENTRIES];
  lks_pkg::occ_t  occ_r, occ_nxt;

  lks_pkg::key_t    key;
  lks_pkg::lookup_t lk;
  lks_pkg::occ_t    cap_eff;
  logic             promote;
  lks_pkg::idx_t    sel;
  logic [lks_pkg::PR_W-1:0] sel_rank;
  logic             do_insert;
  logic [lks_pkg::ENTRIES-1:0] valid_vec;

  assign key = lks_pkg::key_from_field(item.key);

  lks_lookup u_lookup (
    .key   (key),
    .valid (valid_r),
    .keys  (keys_r),
    .ranks (ranks_r),
    .occ   (occ_r),
    .lk    (lk)
  );

  always_comb begin
    if (cap == '0) begin
      cap_eff = lks_pkg::OCC_W'(1);
    end else if (32'(cap) > lks_pkg::ENTRIES) begin
      cap_eff = lks_pkg::OCC_W'(lks_pkg::ENTRIES);
    end else begin
      cap_eff = lks_pkg::OCC_W'(cap);
    end
  end

  always_comb begin
    keys_nxt  = keys_r;
    valid_nxt = valid_r;
    ranks_nxt = ranks_r;
    occ_nxt   = occ_r;
    promote   = 1'b0;
    do_insert = 1'b0;
    sel       = lk.hit_idx;
    sel_rank  = {1'b0, lk.hit_rank};
    res       = '0;
    if (item.req_type == lks_pkg::REQ_GET) begin
      if (lk.hit) begin
        promote        = 1'b1;
        res.status     = lks_pkg::ST_HIT;
        res.result_key = lks_pkg::key_to_field(key);
      end else begin
        res.status = lks_pkg::ST_MISS;
      end
    end else if (lk.hit) begin
      res.status = lks_pkg::ST_PRESENT;
    end else if (occ_r < cap_eff) begin
      promote    = 1'b1;
      do_insert  = 1'b1;
      sel        = lk.free_idx;
      sel_rank   = lks_pkg::PR_W'(lks_pkg::ENTRIES);
      occ_nxt    = occ_r + lks_pkg::OCC_W'(1);
      res.status = lks_pkg::ST_INSERTED;
    end else begin
      promote         = 1'b1;
      sel             = lk.victim_idx;
      sel_rank        = lks_pkg::PR_W'(occ_r - lks_pkg::OCC_W'(1));
      res.status      = lks_pkg::ST_EVICTED;
      res.evicted_key = lks_pkg::key_to_field(keys_r[lk.victim_idx]);
      keys_nxt[lk.victim_idx] = key;
    end
    if (do_insert) begin
      keys_nxt[sel]  = key;
      valid_nxt[sel] = 1'b1;
    end
    if (promote) begin
      for (int i = 0; i < lks_pkg::ENTRIES; i++) begin
        if (valid_r[i] && (lks_pkg::IDX_W'(i) != sel) && ({1'b0, ranks_r[i]} < sel_rank)) begin
          ranks_nxt[i] = ranks_r[i] + lks_pkg::RANK_W'(1);
        end
      end
      ranks_nxt[sel] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      keys_r <= keys_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lks_pkg::ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        ranks_r[i] <= '0;
      end
      occ_r <= '0;
    end else if (fire) begin
      valid_r <= valid_nxt;
      ranks_r <= ranks_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < lks_pkg::ENTRIES; i++) begin
      valid_vec[i] = valid_r[i];
    end
  end

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(occ_r))
    else $error("occupancy does not match valid entries");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= lks_pkg::ENTRIES)
    else $error("occupancy above entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && do_insert) |=> (occ_r == $past(occ_r) + lks_pkg::OCC_W'(1)))
    else $error("insert did not grow occupancy");

endmodule

// ===== tb/lru_key_set_tb.sv =====
`timescale 1ns / 1ps

module lru_key_set_tb;

  typedef enum logic [1:0] {
    ROW_PUT,
    ROW_GET,
    ROW_CAP
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [31:0]        arg;
    logic               typed;
    lks_pkg::out_item_t want;
  } row_t;

  localparam int WARMUP_ROWS  = 24;
  localparam int SEGMENTS     = 6;
  localparam int SEG_ITEMS    = 108;
  localparam int POOL_SIZE    = 24;
  localparam int SETTLE_CYC   = 3;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;

  // typed expectations only where the answer is plain from an empty set
  localparam row_t WARMUP [WARMUP_ROWS] = '{
    '{ROW_GET, 32'h0000_0000, 1'b1, '{lks_pkg::ST_MISS,     32'sh0,         32'sh0}},
    '{ROW_PUT, 32'h8000_0000, 1'b1, '{lks_pkg::ST_INSERTED, 32'sh0,         32'sh0}},
    '{ROW_PUT, 32'h7FFF_FFFF, 1'b1, '{lks_pkg::ST_INSERTED, 32'sh0,         32'sh0}},
    '{ROW_PUT, 32'h0000_0000, 1'b1, '{lks_pkg::ST_INSERTED, 32'sh0,         32'sh0}},
    '{ROW_PUT, 32'hFFFF_FFFF, 1'b1, '{lks_pkg::ST_INSERTED, 32'sh0,         32'sh0}},
    '{ROW_PUT, 32'h8000_0000, 1'b1, '{lks_pkg::ST_PRESENT,  32'sh0,         32'sh0}},
    '{ROW_GET, 32'h7FFF_FFFF, 1'b1, '{lks_pkg::ST_HIT,      32'sh7FFF_FFFF, 32'sh0}},
    '{ROW_GET, 32'h0000_0005, 1'b1, '{lks_pkg::ST_MISS,     32'sh0,         32'sh0}},
    '{ROW_GET, 32'hFFFF_FFFF, 1'b1, '{lks_pkg::ST_HIT,      32'shFFFF_FFFF, 32'sh0}},
    '{ROW_CAP, 32'd4,         1'b0, '0},
    '{ROW_PUT, 32'h0000_0100, 1'b0, '0},
    '{ROW_PUT, 32'h0000_0000, 1'b0, '0},
    '{ROW_GET, 32'h8000_0000, 1'b0, '0},
    '{ROW_CAP, 32'd0,         1'b0, '0},
    '{ROW_PUT, 32'h0000_0200, 1'b0, '0},
    '{ROW_GET, 32'h0000_0200, 1'b0, '0},
    '{ROW_PUT, 32'h0000_0300, 1'b0, '0},
    '{ROW_CAP, 32'd31,        1'b0, '0},
    '{ROW_PUT, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_PUT, 32'h5555_5555, 1'b0, '0},
    '{ROW_GET, 32'h0000_0100, 1'b0, '0},
    '{ROW_CAP, 32'd1,         1'b0, '0},
    '{ROW_PUT, 32'h0000_0400, 1'b0, '0},
    '{ROW_GET, 32'h7FFF_FFFF, 1'b0, '0}
  };

  localparam logic [lks_pkg::CAP_W-1:0] CAP_PLAN [SEGMENTS] =
    '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd9};

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  lks_pkg::in_item_t            in_data;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  lks_pkg::out_item_t           out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [lks_pkg::CAP_W-1:0]    cfg_data;

  // predictor state
  lks_pkg::key_t                set_keys  [lks_pkg::ENTRIES];
  logic                         set_valid [lks_pkg::ENTRIES];
  lks_pkg::rank_t               set_rank  [lks_pkg::ENTRIES];
  int unsigned                  set_fill;
  logic [lks_pkg::CAP_W-1:0]    set_cap;

  lks_pkg::out_item_t           expected_q [$];
  int                           mismatches;
  int                           results_by_status [8];
  int                           send_gap_pct;
  int                           hold_pct;
  int                           caps_used;
  lks_pkg::key_t                key_pool [POOL_SIZE];
  lks_pkg::out_item_t           want_now;

  lru_key_set DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #5_000_000;
    $display("lru_key_set regression: fail");
    $finish;
  end

  // moves slot s to the front; every valid slot ranked ahead of lim drops back one
  function automatic void lru_touch(int s, int unsigned lim);
    for (int i = 0; i < lks_pkg::ENTRIES; i++)
      if (set_valid[i] && i != s && set_rank[i] < lim)
        set_rank[i] = set_rank[i] + 1'b1;
    set_rank[s] = '0;
  endfunction

  function automatic lks_pkg::out_item_t lru_apply(lks_pkg::in_item_t req);
    lks_pkg::out_item_t r;
    lks_pkg::key_t      k;
    int                 slot;
    int                 victim;
    int unsigned        lim;
    r    = '0;
    k    = lks_pkg::key_t'(req.key);
    slot = -1;
    for (int i = 0; i < lks_pkg::ENTRIES; i++)
      if (set_valid[i] && set_keys[i] == k)
        slot = i;
    if (req.req_type == lks_pkg::REQ_GET) begin
      if (slot >= 0) begin
        lru_touch(slot, set_rank[slot]);
        r.status     = lks_pkg::ST_HIT;
        r.result_key = set_keys[slot];
      end else begin
        r.status = lks_pkg::ST_MISS;
      end
    end else if (slot >= 0) begin
      r.status = lks_pkg::ST_PRESENT;
    end else begin
      lim = (set_cap == 0) ? 1 : (set_cap > lks_pkg::ENTRIES) ? lks_pkg::ENTRIES : set_cap;
      if (set_fill < lim)
        for (int i = lks_pkg::ENTRIES - 1; i >= 0; i--)
          if (!set_valid[i])
            slot = i;
      if (slot >= 0) begin
        set_valid[slot] = 1'b1;
        set_keys[slot]  = k;
        lru_touch(slot, lks_pkg::ENTRIES);
        set_fill++;
        r.status = lks_pkg::ST_INSERTED;
      end else begin
        victim = -1;
        for (int i = 0; i < lks_pkg::ENTRIES; i++)
          if (set_valid[i] && (victim < 0 || set_rank[i] > set_rank[victim]))
            victim = i;
        if (victim < 0) begin
          victim   = 0;
          set_fill = 1;
        end
        r.evicted_key     = set_keys[victim];
        set_keys[victim]  = k;
        set_valid[victim] = 1'b1;
        lru_touch(victim, set_rank[victim]);
        r.status = lks_pkg::ST_EVICTED;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, lks_pkg::out_item_t want,
                                 lks_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: want st=%0d res=%h ev=%h, got st=%0d res=%h ev=%h", $realtime, what,
               want.status, want.result_key, want.evicted_key,
               got.status, got.result_key, got.evicted_key);
  endtask

  // result side: check each beat against the oldest expectation, then choose the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_by_status[out_data.status]++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", '0, out_data);
      end else begin
        want_now = expected_q.pop_front();
        if (out_data.status !== want_now.status ||
            out_data.result_key !== want_now.result_key ||
            out_data.evicted_key !== want_now.evicted_key)
          report_mismatch("mismatch", want_now, out_data);
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < hold_pct);
  end

  // offers one request beat; valid is left high on return
  task automatic send_request(lks_pkg::in_item_t req, logic typed, lks_pkg::out_item_t want);
    lks_pkg::out_item_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predicted = lru_apply(req);
    expected_q.push_back(typed ? want : predicted);
  endtask

  task automatic set_capacity(logic [lks_pkg::CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_cap = cap;
    caps_used++;
  endtask

  initial begin
    lks_pkg::in_item_t req;
    int                pool_hi;
    int                waited;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    mismatches   = 0;
    caps_used    = 0;
    send_gap_pct = 19;
    hold_pct     = 75;
    foreach (results_by_status[i]) results_by_status[i] = 0;
    foreach (set_valid[i]) begin
      set_valid[i] = 1'b0;
      set_rank[i]  = '0;
      set_keys[i]  = '0;
    end
    set_fill = 0;
    set_cap  = lks_pkg::CAP_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < WARMUP_ROWS; r++) begin
      if (WARMUP[r].kind == ROW_CAP) begin
        set_capacity(WARMUP[r].arg[lks_pkg::CAP_W-1:0]);
      end else begin
        req.req_type = (WARMUP[r].kind == ROW_GET) ? lks_pkg::REQ_GET : lks_pkg::REQ_PUT;
        req.key      = WARMUP[r].arg;
        send_request(req, WARMUP[r].typed, WARMUP[r].want);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_capacity(CAP_PLAN[seg]);
      send_gap_pct = (seg < 2) ? 19 : (seg < 4) ? 75 : 0;
      hold_pct     = (seg < 2) ? 75 : (seg < 4) ? 19 : 0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      // pool a little larger than the capacity keeps hits and evictions both common
      pool_hi = (CAP_PLAN[seg] > lks_pkg::ENTRIES) ? lks_pkg::ENTRIES + 3
                                                   : CAP_PLAN[seg] + 3;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        req.req_type = $urandom_range(0, 1) ? lks_pkg::REQ_GET : lks_pkg::REQ_PUT;
        req.key      = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, pool_hi)]
                                                    : $urandom;
        send_request(req, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0) begin
      mismatches += expected_q.size();
      $display("%0d expected beats never arrived", expected_q.size());
    end

    $display("covered %0d capacity settings under three handshake pressure mixes",
             caps_used);
    $display("results seen: %0d inserted, %0d present, %0d evicted, %0d hits, %0d misses",
             results_by_status[lks_pkg::ST_INSERTED], results_by_status[lks_pkg::ST_PRESENT],
             results_by_status[lks_pkg::ST_EVICTED], results_by_status[lks_pkg::ST_HIT],
             results_by_status[lks_pkg::ST_MISS]);
    if (mismatches == 0) begin
      $display("lru_key_set regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("lru_key_set regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lks_pkg.sv
rtl/lks_lookup.sv
rtl/lks_store.sv
rtl/lru_key_set.sv
tb/lru_key_set_tb.sv
